[rtl/core/adnp_pkg.sv]
`timescale 1ns / 1ps

package adnp_pkg;

    localparam int MANT_W = 60;
    localparam int FRAC_W = 6;
    localparam int EXP_W  = 10;

    localparam logic [63:0] MANT_CAP = (64'd1 << MANT_W) - 64'd1;
    localparam logic [63:0] EXP_CAP  = (64'd1 << EXP_W) - 64'd1;
    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

    // Byte classes decided by the front part.
    localparam logic [2:0] CLS_BLANK = 3'd0;
    localparam logic [2:0] CLS_DIGIT = 3'd1;
    localparam logic [2:0] CLS_DOT   = 3'd2;
    localparam logic [2:0] CLS_E     = 3'd3;
    localparam logic [2:0] CLS_MINUS = 3'd4;
    localparam logic [2:0] CLS_OTHER = 3'd5;
    localparam logic [2:0] CLS_EOF   = 3'd6;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DOT  = 2'd1;
    localparam logic [1:0] ERR_E    = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] digit;
        logic [7:0] ch;
    } adnp_item_t;

    typedef struct packed {
        logic              negative;
        logic [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0] frac_digits;
        logic              exp_negative;
        logic [EXP_W-1:0]  exp_value;
        logic [7:0]        terminator;
        logic              ended_by_eof;
        logic [1:0]        error_code;
        logic              overflow;
    } adnp_result_t;

    // All nines with the given digit count, capped; evaluated at elaboration.
    function automatic logic [63:0] nines_limit(input int digits, input logic [63:0] cap);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < 19; i++)
        begin
            if (i < digits)
            begin
                v = v * 64'd10;
            end
        end
        v = v - 64'd1;
        return (v > cap) ? cap : v;
    endfunction

endpackage

[rtl/core/ascii_decimal_number_parser.sv]
`timescale 1ns / 1ps

// Streaming parser that splits ASCII decimal numbers such as "-12.50e-3" into parts.
// Input side is a queue: drive ch (or end_of_stream) with push; the item is taken on
// a clock edge where push is high and full is low, so one byte can be taken every cycle.
// Output side is a queue too: while empty is low the oldest number is on the result
// ports, and pop on a clock edge with empty low takes it.
// A front stage classifies each byte into a two-entry queue; the back stage updates
// the accumulators and writes each finished number into a two-entry result queue.
// A result is on the ports in the cycle after the back stage takes its terminating byte;
// the back stage handles one byte per cycle while the result queue has room.
// When the receiver stops popping, the result queue fills, the back stage holds, and
// full rises once the byte queue is also full; nothing is dropped.
// Reset is asynchronous and active low: it empties both queues and returns the parser
// to idle with all accumulators cleared. Blanks are skipped while idle, and the
// terminator byte is consumed with the number that it ends.
module ascii_decimal_number_parser
    import adnp_pkg::*;
#(
    parameter int MANTISSA_DIGITS = 18,
    parameter int EXPONENT_DIGITS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        ch,
    input  logic              end_of_stream,
    output logic              empty,
    input  logic              pop,
    output logic              negative,
    output logic [MANT_W-1:0] mantissa,
    output logic [FRAC_W-1:0] frac_digits,
    output logic              exp_negative,
    output logic [EXP_W-1:0]  exp_value,
    output logic [7:0]        terminator,
    output logic              ended_by_eof,
    output logic [1:0]        error_code,
    output logic              overflow
);

    adnp_item_t   q_item;
    logic         q_valid;
    logic         q_pop;
    adnp_result_t res;

    adnp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .ch           (ch),
        .end_of_stream(end_of_stream),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .q_valid      (q_valid)
    );

    adnp_back #(
        .MANTISSA_DIGITS(MANTISSA_DIGITS),
        .EXPONENT_DIGITS(EXPONENT_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .res      (res),
        .res_empty(empty),
        .res_pop  (pop)
    );

    assign negative     = res.negative;
    assign mantissa     = res.mantissa;
    assign frac_digits  = res.frac_digits;
    assign exp_negative = res.exp_negative;
    assign exp_value    = res.exp_value;
    assign terminator   = res.terminator;
    assign ended_by_eof = res.ended_by_eof;
    assign error_code   = res.error_code;
    assign overflow     = res.overflow;

endmodule

[rtl/core/adnp_fifo.sv]
`timescale 1ns / 1ps

module adnp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/core/adnp_front.sv]
`timescale 1ns / 1ps

module adnp_front
    import adnp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] ch,
    input  logic       end_of_stream,
    input  logic       q_pop,
    output adnp_item_t q_item,
    output logic       q_valid
);

    adnp_item_t item_in;
    logic       q_empty;

    always_comb
    begin
        item_in.ch    = ch;
        item_in.digit = ch[3:0];
        if (end_of_stream)
        begin
            item_in.cls = CLS_EOF;
            item_in.ch  = 8'd0;
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            item_in.cls = CLS_DIGIT;
        end
        else if (ch == CH_DOT)
        begin
            item_in.cls = CLS_DOT;
        end
        else if (ch == CH_E)
        begin
            item_in.cls = CLS_E;
        end
        else if (ch == CH_MINUS)
        begin
            item_in.cls = CLS_MINUS;
        end
        else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR)
        begin
            item_in.cls = CLS_BLANK;
        end
        else
        begin
            item_in.cls = CLS_OTHER;
        end
    end

    adnp_fifo #(
        .WIDTH($bits(adnp_item_t))
    ) u_item_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (item_in),
        .full (full),
        .pop  (q_pop),
        .dout (q_item),
        .empty(q_empty)
    );

    assign q_valid = !q_empty;

endmodule

[rtl/core/adnp_back.sv]
`timescale 1ns / 1ps

module adnp_back
    import adnp_pkg::*;
#(
    parameter int MANTISSA_DIGITS = 18,
    parameter int EXPONENT_DIGITS = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  adnp_item_t   q_item,
    input  logic         q_valid,
    output logic         q_pop,
    output adnp_result_t res,
    output logic         res_empty,
    input  logic         res_pop
);

    localparam logic [63:0] MANT_LIM64 = nines_limit(MANTISSA_DIGITS, MANT_CAP);
    localparam logic [63:0] EXP_LIM64  = nines_limit(EXPONENT_DIGITS, EXP_CAP);
    localparam logic [MANT_W-1:0] MANT_LIM = MANT_LIM64[MANT_W-1:0];
    localparam logic [EXP_W+3:0]  EXP_LIM  = {4'd0, EXP_LIM64[EXP_W-1:0]};

    logic              in_number_reg, in_number_next;
    logic              neg_reg, neg_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic              exp_neg_reg, exp_neg_next;
    logic              seen_dot_reg, seen_dot_next;
    logic              seen_e_reg, seen_e_next;
    logic [1:0]        err_reg, err_next;
    logic              ovf_reg, ovf_next;

    logic              res_full;
    logic              take;
    logic              emit;
    logic              parse;
    logic [63:0]       mant_sum;
    logic [EXP_W+3:0]  exp_sum;
    adnp_result_t      res_in;

    // Times ten as two shifts; the accumulators never exceed their limits.
    assign mant_sum = {1'b0, mant_reg, 3'b000} + {3'b000, mant_reg, 1'b0}
                      + {60'd0, q_item.digit};
    assign exp_sum  = {1'b0, exp_reg, 3'b000} + {3'b000, exp_reg, 1'b0}
                      + {10'd0, q_item.digit};

    assign take  = q_valid && !res_full;
    assign q_pop = take;

    always_comb
    begin
        in_number_next = in_number_reg;
        neg_next       = neg_reg;
        mant_next      = mant_reg;
        frac_next      = frac_reg;
        exp_next       = exp_reg;
        exp_neg_next   = exp_neg_reg;
        seen_dot_next  = seen_dot_reg;
        seen_e_next    = seen_e_reg;
        err_next       = err_reg;
        ovf_next       = ovf_reg;
        emit           = 1'b0;
        parse          = 1'b0;

        if (q_item.cls == CLS_EOF)
        begin
            emit = 1'b1;
        end
        else if (!in_number_reg)
        begin
            if (q_item.cls != CLS_BLANK)
            begin
                in_number_next = 1'b1;
                if (q_item.cls == CLS_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else
                begin
                    parse = 1'b1;
                end
            end
        end
        else
        begin
            parse = 1'b1;
        end

        if (parse)
        begin
            case (q_item.cls)
                CLS_DIGIT:
                begin
                    if (seen_e_reg)
                    begin
                        if (exp_sum > EXP_LIM)
                        begin
                            exp_next = EXP_LIM[EXP_W-1:0];
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            exp_next = exp_sum[EXP_W-1:0];
                        end
                    end
                    else
                    begin
                        if (mant_sum > {4'd0, MANT_LIM})
                        begin
                            mant_next = MANT_LIM;
                            ovf_next  = 1'b1;
                        end
                        else
                        begin
                            mant_next = mant_sum[MANT_W-1:0];
                        end
                        if (seen_dot_reg)
                        begin
                            if (frac_reg == FRAC_MAX)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                frac_next = frac_reg + {{(FRAC_W-1){1'b0}}, 1'b1};
                            end
                        end
                    end
                end
                CLS_DOT:
                begin
                    if (seen_dot_reg)
                    begin
                        if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_DOT;
                        end
                    end
                    else
                    begin
                        seen_dot_next = 1'b1;
                    end
                end
                CLS_E:
                begin
                    if (seen_e_reg)
                    begin
                        if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_E;
                        end
                    end
                    else
                    begin
                        seen_e_next = 1'b1;
                    end
                end
                CLS_MINUS:
                begin
                    if (seen_e_reg)
                    begin
                        exp_neg_next = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    emit = 1'b1;
                end
            endcase
        end

        // A finished number reports the state as it stood and starts over.
        if (emit)
        begin
            in_number_next = 1'b0;
            neg_next       = 1'b0;
            mant_next      = '0;
            frac_next      = '0;
            exp_next       = '0;
            exp_neg_next   = 1'b0;
            seen_dot_next  = 1'b0;
            seen_e_next    = 1'b0;
            err_next       = ERR_NONE;
            ovf_next       = 1'b0;
        end
    end

    always_comb
    begin
        res_in.negative     = neg_reg;
        res_in.mantissa     = mant_reg;
        res_in.frac_digits  = frac_reg;
        res_in.exp_negative = exp_neg_reg;
        res_in.exp_value    = exp_reg;
        res_in.terminator   = q_item.ch;
        res_in.ended_by_eof = (q_item.cls == CLS_EOF);
        res_in.error_code   = err_reg;
        res_in.overflow     = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_number_reg <= 1'b0;
            neg_reg       <= 1'b0;
            mant_reg      <= '0;
            frac_reg      <= '0;
            exp_reg       <= '0;
            exp_neg_reg   <= 1'b0;
            seen_dot_reg  <= 1'b0;
            seen_e_reg    <= 1'b0;
            err_reg       <= ERR_NONE;
            ovf_reg       <= 1'b0;
        end
        else if (take)
        begin
            in_number_reg <= in_number_next;
            neg_reg       <= neg_next;
            mant_reg      <= mant_next;
            frac_reg      <= frac_next;
            exp_reg       <= exp_next;
            exp_neg_reg   <= exp_neg_next;
            seen_dot_reg  <= seen_dot_next;
            seen_e_reg    <= seen_e_next;
            err_reg       <= err_next;
            ovf_reg       <= ovf_next;
        end
    end

    adnp_fifo #(
        .WIDTH($bits(adnp_result_t))
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (take && emit),
        .din  (res_in),
        .full (res_full),
        .pop  (res_pop),
        .dout (res),
        .empty(res_empty)
    );

endmodule
